@@ hw/rtl/syracuse_trajectory_phase_defines.svh @@
// Assertion macros used by the checker file of the trajectory block.
`ifndef SYRACUSE_TRAJECTORY_PHASE_DEFINES_SVH
`define SYRACUSE_TRAJECTORY_PHASE_DEFINES_SVH

// Property checked on every rising clock edge, masked while reset is held.
`define SYT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset cycles included.
`define SYT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/syt_pkg.sv @@
// Types, constants and helper functions of the Syracuse trajectory block.
`timescale 1ns / 1ps
package syt_pkg;

  localparam int unsigned SEED_W          = 128;
  localparam int unsigned STEP_W          = 6;
  localparam int unsigned SUM_W           = 8;
  localparam int unsigned OUT_SUM_W       = 7;
  localparam int unsigned PHASE_W         = 64;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam logic [SUM_W-1:0]  VALUATION_LIMIT = 8'd120;
  localparam logic [STEP_W-1:0] MAX_STEPS_RESET = 6'd63;

  typedef struct packed {
    logic [SEED_W-1:0] seed;
    logic [STEP_W-1:0] limit;
  } syt_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CTZ,
    ST_SHIFT,
    ST_COMMIT,
    ST_FLUSH
  } syt_state_t;

  // Trailing zero count of a 128-bit word; an all-zero word counts as 128.
  function automatic logic [SUM_W-1:0] syt_ctz(input logic [SEED_W-1:0] y);
    logic [SEED_W-1:0] t;
    logic [SUM_W-1:0]  n;
    t = y;
    n = '0;
    if (y == '0) begin
      n = 8'd128;
    end else begin
      for (int i = 6; i >= 0; i--) begin
        if ((t & ((128'd1 << (1 << i)) - 128'd1)) == '0) begin
          n[i] = 1'b1;
          t = t >> (1 << i);
        end
      end
    end
    return n;
  endfunction

  // Top-aligned 0.64 fraction of (mu mod 2^k) / 2^k, for k from 1 to 127.
  function automatic logic [PHASE_W-1:0] syt_phase(input logic [SEED_W-1:0] mu,
                                                   input logic [6:0] k);
    logic [SEED_W-1:0] m;
    logic [SEED_W-1:0] t;
    logic [6:0]        sh;
    m  = mu & ~({SEED_W{1'b1}} << k);
    sh = 7'd0 - k;
    t  = m << sh;
    return t[SEED_W-1:SEED_W-PHASE_W];
  endfunction

endpackage

@@ hw/rtl/syracuse_trajectory_phase.sv @@
// Top level of the accelerated Collatz (Syracuse) trajectory and phase block.
`timescale 1ns / 1ps
// Each input word is one 128-bit seed; bit 0 of the seed is forced to one.
// The block runs x = (3x+1) / 2^v modulo 2^128 from that seed, keeps the
// running sum S of the valuations v, and for step N = 1 .. max_steps sends one
// output word: N, S and the seed's residue modulo 2^(S+1) as a 0.64 fraction.
// A run ends without a word for the step at which S+1 would pass 120; the
// last word sent for a seed carries tlast. A run of zero steps sends nothing.
// Map steps: the first 3x+1 runs in a state of its own, then each map step
// passes through the shared 128-bit datapath as trailing-zero count, shift,
// and commit with the next 3x+1; the commit waits while a held word cannot
// move on to the output register.
// A two-entry seed queue lets the input side accept new seeds while the
// engine is busy; in_tready drops only when that queue is full.
// When the receiver stalls, the output register holds its word and the engine
// waits with at most one further word held inside; nothing is lost.
// Synchronous reset empties the queue, idles the engine, clears out_tvalid
// and sets max_steps back to 63. max_steps is written through cfg_wr_en.
module syracuse_trajectory_phase (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [5:0]   cfg_wr_data,   // max_steps
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,      // seed_high [63:0], seed_low [127:64]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata,     // step_index [5:0], valuation_sum [12:6],
                                      // phase [76:13], zero fill [79:77]
  output logic         out_tlast      // last word of the seed's run
);
  import syt_pkg::*;

  logic [STEP_W-1:0] max_steps_r;
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  syt_item_t         push_item;
  syt_item_t         pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steps_r <= MAX_STEPS_RESET;
    end else if (cfg_wr_en) begin
      max_steps_r <= cfg_wr_data;
    end
  end

  syt_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .max_steps (max_steps_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  syt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  syt_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ hw/rtl/syt_front.sv @@
// Input side: takes seed words, forces the seed odd and drops zero-step runs.
`timescale 1ns / 1ps
module syt_front (
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [127:0]                in_tdata,
  input  logic [syt_pkg::STEP_W-1:0]  max_steps,
  input  logic                        q_full,
  output logic                        q_push,
  output syt_pkg::syt_item_t          q_item
);
  import syt_pkg::*;

  logic accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // A run of zero steps gives no result, so it never reaches the queue.
  assign q_push       = accept && (max_steps != '0);
  assign q_item.seed  = {in_tdata[63:0], in_tdata[127:65], 1'b1};
  assign q_item.limit = max_steps;

endmodule

@@ hw/rtl/syt_queue.sv @@
// Short queue of classified seeds between the input side and the engine.
`timescale 1ns / 1ps
module syt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  syt_pkg::syt_item_t push_item,
  input  logic               pop,
  output syt_pkg::syt_item_t pop_item,
  output logic               full,
  output logic               empty
);
  import syt_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  syt_item_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hw/rtl/syt_engine.sv @@
// Back end: iterates the Syracuse map on one seed and emits the result words.
`timescale 1ns / 1ps
module syt_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  syt_pkg::syt_item_t           q_item,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [79:0]                  out_tdata,
  output logic                         out_tlast
);
  import syt_pkg::*;

  syt_state_t              state_r, state_nxt;
  logic [SEED_W-1:0]       mu_r, mu_nxt;
  logic [SEED_W-1:0]       x_r, x_nxt;
  logic [SEED_W-1:0]       y_r, y_nxt;
  logic [SUM_W-1:0]        v_r, v_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [STEP_W-1:0]       limit_r, limit_nxt;

  logic                    pend_valid_r, pend_valid_nxt;
  logic [STEP_W-1:0]       pend_step_r, pend_step_nxt;
  logic [OUT_SUM_W-1:0]    pend_sum_r, pend_sum_nxt;
  logic [PHASE_W-1:0]      pend_phase_r, pend_phase_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [STEP_W-1:0]       out_step_r, out_step_nxt;
  logic [OUT_SUM_W-1:0]    out_sum_r, out_sum_nxt;
  logic [PHASE_W-1:0]      out_phase_r, out_phase_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [SEED_W-1:0]       y_calc;
  logic [SUM_W-1:0]        sum_add;
  logic                    out_free;

  // 3x+1 modulo 2^128.
  assign y_calc   = x_r + {x_r[SEED_W-2:0], 1'b0} + 128'd1;
  assign sum_add  = sum_r + v_r;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    mu_nxt         = mu_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    v_nxt          = v_r;
    sum_nxt        = sum_r;
    step_nxt       = step_r;
    limit_nxt      = limit_r;
    pend_valid_nxt = pend_valid_r;
    pend_step_nxt  = pend_step_r;
    pend_sum_nxt   = pend_sum_r;
    pend_phase_nxt = pend_phase_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_step_nxt   = out_step_r;
    out_sum_nxt    = out_sum_r;
    out_phase_nxt  = out_phase_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          mu_nxt    = q_item.seed;
          x_nxt     = q_item.seed;
          limit_nxt = q_item.limit;
          sum_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        y_nxt     = y_calc;
        step_nxt  = step_r + 1'b1;
        state_nxt = ST_CTZ;
      end
      ST_CTZ: begin
        v_nxt     = syt_ctz(y_r);
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        x_nxt   = y_r >> v_r;
        sum_nxt = sum_add;
        // Crossing the valuation limit ends the run with no word for this step.
        if (sum_add >= VALUATION_LIMIT) begin
          state_nxt = pend_valid_r ? ST_FLUSH : ST_IDLE;
        end else begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // The held word is known not to be last once this step survived.
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_step_nxt  = pend_step_r;
            out_sum_nxt   = pend_sum_r;
            out_phase_nxt = pend_phase_r;
            out_last_nxt  = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_step_nxt  = step_r;
          pend_sum_nxt   = sum_r[OUT_SUM_W-1:0];
          pend_phase_nxt = syt_phase(mu_r, sum_r[OUT_SUM_W-1:0] + 7'd1);
          if (step_r == limit_r) begin
            state_nxt = ST_FLUSH;
          end else begin
            y_nxt     = y_calc;
            step_nxt  = step_r + 1'b1;
            state_nxt = ST_CTZ;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_step_nxt   = pend_step_r;
          out_sum_nxt    = pend_sum_r;
          out_phase_nxt  = pend_phase_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      sum_r        <= '0;
      step_r       <= '0;
      limit_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      sum_r        <= sum_nxt;
      step_r       <= step_nxt;
      limit_r      <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mu_r         <= mu_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    v_r          <= v_nxt;
    pend_step_r  <= pend_step_nxt;
    pend_sum_r   <= pend_sum_nxt;
    pend_phase_r <= pend_phase_nxt;
    out_step_r   <= out_step_nxt;
    out_sum_r    <= out_sum_nxt;
    out_phase_r  <= out_phase_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_phase_r, out_sum_r, out_step_r};

endmodule

@@ hw/rtl/syt_checker.sv @@
// Port-level assertions for the trajectory block, with the bind that attaches them.
`timescale 1ns / 1ps
`include "syracuse_trajectory_phase_defines.svh"
module syt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [79:0]  out_tdata,
  input logic         out_tlast
);

  logic       mid_run_r;
  logic [5:0] prev_step_r;
  logic [6:0] prev_sum_r;

  // Remembers the previous word of a run still in progress.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_run_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      mid_run_r <= !out_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      prev_step_r <= out_tdata[5:0];
      prev_sum_r  <= out_tdata[12:6];
    end
  end

  `SYT_ASSERT_ALWAYS(a_reset_clears_valid, !rst_n |=> !out_tvalid, "out_tvalid after reset")
  `SYT_ASSERT(a_stall_holds, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output word changed")
  `SYT_ASSERT(a_word_range, out_tvalid |-> out_tdata[5:0] != 6'd0 && out_tdata[12:6] < 7'd120, "step or valuation sum out of range")
  `SYT_ASSERT(a_run_order, out_tvalid && mid_run_r |-> out_tdata[5:0] == prev_step_r + 6'd1 && out_tdata[12:6] > prev_sum_r, "run words out of order")

endmodule

bind syracuse_trajectory_phase syt_checker u_syt_checker (.*);
